FILE: rtl/core/swel_pkg.sv
// Package with shared widths, register codes and helpers for the sliding-window event limiter.
`default_nettype none
package swel_pkg;

  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned RING_W        = 5;
  localparam int unsigned HELD_W        = 4;
  localparam int unsigned MAX_SLOTS_DEF = 16;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;

  localparam logic [RING_W-1:0] RING_RESET = 5'd16;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_RING   = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // Capacity of the ring for a given slot setting, clamped to the legal range.
  function automatic int unsigned ring_cap(input logic [RING_W-1:0] rs,
                                           input int unsigned max_slots);
    int unsigned eff;
    eff = int'(rs);
    if (eff < 2) eff = 2;
    if (eff > max_slots) eff = max_slots;
    return eff - 1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/swel_cell.sv
// One timestamp cell of the age-ordered chain.
`default_nettype none
module swel_cell
  import swel_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic [STAMP_W-1:0] shift_in,
  input  wire logic [STAMP_W-1:0] load_data,
  output logic      [STAMP_W-1:0] stamp
);

  logic [STAMP_W-1:0] stamp_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      stamp_r <= shift_in;
    end else if (ctl.load) begin
      stamp_r <= load_data;
    end
  end

  assign stamp = stamp_r;

endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_event_limiter_top.sv
// Top level of the sliding-window event limiter: config registers, control and cell chain.
//
//   channel | ports                       | direction | beat
//   input   | in_valid/in_ready           | in        | event_time
//   result  | out_valid/out_ready         | out       | flood_detected, recorded, entries_held
//   config  | psel/penable/pwrite/paddr.. | in        | window_ticks at 0x0, ring_size at 0x4
//
// An event finishes in S_CHECK when the ring has room or a flood is seen; otherwise in
// S_EVICT the chain drops one stamp from its oldest end per cycle while it is expired.
// The result sits in an output register, so a new beat is accepted while it waits.
// A finished result waits in place while the previous one has not been taken.
// Reset is synchronous and empties the ring; a ring_size write empties it too.
`default_nettype none
module sliding_window_event_limiter_top
  import swel_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [STAMP_W-1:0] in_event_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_flood_detected,
  output logic                    out_recorded,
  output logic      [HELD_W-1:0]  out_entries_held,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  localparam int unsigned NC = MAX_SLOTS - 1;
  localparam int unsigned CW = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EVICT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [STAMP_W-1:0] window_r;
  logic [RING_W-1:0]  ring_r;
  logic [CW-1:0]      cap_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [STAMP_W-1:0] time_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_flood_r, out_rec_r;
  logic [HELD_W-1:0]  out_held_r;

  logic               cfg_wr;
  reg_sel_t           reg_sel;
  logic [STAMP_W-1:0] stamp [NC];
  logic [STAMP_W-1:0] age;
  logic               flood_hit, expired, out_free;
  logic               do_shift, do_load, finish, res_flood, res_rec;
  logic [31:0]        held_ext;
  logic [HELD_W-1:0]  held_sat;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW: prdata = window_r;
      REG_RING:   prdata = DATA_W'(ring_r);
      default:    prdata = '0;
    endcase
  end

  assign age       = time_r - stamp[0];
  assign flood_hit = !age[STAMP_W-1] && (age < window_r);
  assign expired   = !age[STAMP_W-1] && (age > window_r);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    do_shift  = 1'b0;
    do_load   = 1'b0;
    finish    = 1'b0;
    res_flood = 1'b0;
    res_rec   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (count_r != cap_r) begin
          if (out_free) begin
            do_load   = 1'b1;
            count_nxt = count_r + 1'b1;
            res_rec   = 1'b1;
            finish    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (flood_hit) begin
          if (out_free) begin
            res_flood = 1'b1;
            finish    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if ((count_r != '0) && expired) begin
          do_shift  = 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (out_free) begin
          if (count_r != cap_r) begin
            do_load   = 1'b1;
            count_nxt = count_r + 1'b1;
            res_rec   = 1'b1;
          end
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign held_ext = 32'(count_nxt);
  assign held_sat = (held_ext > 32'd15) ? 4'd15 : held_ext[HELD_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      window_r    <= '0;
      ring_r      <= RING_RESET;
      cap_r       <= CW'(ring_cap(RING_RESET, MAX_SLOTS));
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (reg_sel == REG_RING)) begin
        count_r <= '0;
      end else begin
        count_r <= count_nxt;
      end
      if (cfg_wr) begin
        if (reg_sel == REG_WINDOW) begin
          window_r <= pwdata;
        end else begin
          ring_r <= pwdata[RING_W-1:0];
          cap_r  <= CW'(ring_cap(pwdata[RING_W-1:0], MAX_SLOTS));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      time_r <= in_event_time;
    end
    if (finish) begin
      out_flood_r <= res_flood;
      out_rec_r   <= res_rec;
      out_held_r  <= held_sat;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cell_ctl_t          ctl;
    logic [STAMP_W-1:0] nb;

    assign ctl = '{shift: do_shift, load: do_load && (count_r == CW'(i))};

    if (i == NC - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = stamp[i+1];
    end

    swel_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (nb),
      .load_data (time_r),
      .stamp     (stamp[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_flood_detected = out_flood_r;
  assign out_recorded       = out_rec_r;
  assign out_entries_held   = out_held_r;

endmodule
`default_nettype wire

FILE: rtl/core/swel_checker.sv
// Port-level checks for the sliding-window event limiter, bound to its top level.
`default_nettype none
module swel_checker
  import swel_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_flood_detected,
  input wire logic              out_recorded,
  input wire logic [HELD_W-1:0] out_entries_held
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flood_detected)
      && $stable(out_recorded) && $stable(out_entries_held))
    else $error("result beat changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_flood_detected && out_recorded))
    else $error("flood and record reported together");

  a_flood_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flood_detected |-> out_entries_held != '0)
    else $error("flood reported with an empty ring");

  a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recorded |-> out_entries_held != '0)
    else $error("stamp recorded but ring reads empty");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind sliding_window_event_limiter_top swel_checker u_swel_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_flood_detected (out_flood_detected),
  .out_recorded       (out_recorded),
  .out_entries_held   (out_entries_held)
);
`default_nettype wire

FILE: test/sliding_window_event_limiter_checker.sv
// Checker that predicts every result beat of the sliding-window event limiter and compares it.
module sliding_window_event_limiter_checker
  import swel_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [STAMP_W-1:0] in_event_time,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               out_flood_detected,
  input  wire logic               out_recorded,
  input  wire logic [HELD_W-1:0]  out_entries_held,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  input  wire logic [DATA_W-1:0]  prdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic              flood;
    logic              rec;
    logic [HELD_W-1:0] held;
  } verdict_t;

  logic [STAMP_W-1:0] ring_stamps [MAX_SLOTS_DEF];
  int unsigned        head;
  int unsigned        tail;
  logic [STAMP_W-1:0] win_len;
  logic [RING_W-1:0]  ring_setting;
  verdict_t           expected_verdicts [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic bit hold_stamp(input int unsigned slots, input logic [STAMP_W-1:0] t);
    int unsigned nxt;
    nxt = (tail + 1) % slots;
    if (nxt == head) return 1'b0;
    ring_stamps[tail] = t;
    tail = nxt;
    return 1'b1;
  endfunction

  function automatic verdict_t police_event(input logic [STAMP_W-1:0] now);
    int unsigned        slots;
    int unsigned        count;
    logic [STAMP_W-1:0] age;
    verdict_t           v;
    slots = ring_setting;
    if (slots < 2) slots = 2;
    if (slots > MAX_SLOTS_DEF) slots = MAX_SLOTS_DEF;
    v = '0;
    head = head % slots;
    tail = tail % slots;
    if (hold_stamp(slots, now)) begin
      v.rec = 1'b1;
    end else begin
      age = now - ring_stamps[head];
      if (age < win_len && !age[STAMP_W-1]) begin
        v.flood = 1'b1;
      end else begin
        while (tail != head) begin
          age = now - ring_stamps[head];
          if (age > win_len && !age[STAMP_W-1]) head = (head + 1) % slots;
          else break;
        end
        v.rec = hold_stamp(slots, now);
      end
    end
    count = (tail + slots - head) % slots;
    v.held = (count > 15) ? HELD_W'(15) : HELD_W'(count);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      win_len      = '0;
      ring_setting = RING_RESET;
      head         = 0;
      tail         = 0;
      expected_verdicts.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_WINDOW, 2'b00}) begin
            win_len = pwdata;
          end else if (paddr == {REG_RING, 2'b00}) begin
            ring_setting = pwdata[RING_W-1:0];
            head         = 0;
            tail         = 0;
          end
        end else if (paddr == {REG_WINDOW, 2'b00} && prdata !== win_len) begin
          $error("window_ticks read: expected %0h, got %0h", win_len, prdata);
          fail_count++;
        end else if (paddr == {REG_RING, 2'b00} && prdata !== DATA_W'(ring_setting)) begin
          $error("ring_size read: expected %0h, got %0h", ring_setting, prdata);
          fail_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_flood_detected !== want.flood) begin
            $error("flood_detected: expected %0d, got %0d", want.flood, out_flood_detected);
            fail_count++;
          end
          if (out_recorded !== want.rec) begin
            $error("recorded: expected %0d, got %0d", want.rec, out_recorded);
            fail_count++;
          end
          if (out_entries_held !== want.held) begin
            $error("entries_held: expected %0d, got %0d", want.held, out_entries_held);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_verdicts.push_back(police_event(in_event_time));
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

FILE: test/tb_sliding_window_event_limiter_top.sv
// Testbench top for the sliding-window event limiter: clock, reset, stimulus and verdict.
module tb_sliding_window_event_limiter_top;
  import swel_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  localparam logic [STAMP_W-1:0] EDGE_STAMPS [13] = '{
    32'd0, 32'd10, 32'd20, 32'd50, 32'd100, 32'h8000_0000, 32'hFFFF_FFFF,
    32'd200, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd5, 32'd250, 32'd320
  };
  localparam logic [STAMP_W-1:0] ZERO_WINDOW_STAMPS [4] = '{32'd1, 32'd1, 32'd2, 32'd2};
  localparam logic [STAMP_W-1:0] FULL_WINDOW_STAMPS [3] = '{
    32'd0, 32'h7FFF_FFFF, 32'h8000_0000
  };

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [STAMP_W-1:0] in_event_time = '0;
  logic               out_ready     = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [DATA_W-1:0]  pwdata        = '0;

  logic               in_ready;
  logic               out_valid;
  logic               out_flood_detected;
  logic               out_recorded;
  logic [HELD_W-1:0]  out_entries_held;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 outstanding;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 cycles      = 0;
  logic [STAMP_W-1:0] now_tick;
  logic [STAMP_W-1:0] cur_window;
  int unsigned        cur_cap;

  sliding_window_event_limiter_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_event_time      (in_event_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_flood_detected (out_flood_detected),
    .out_recorded       (out_recorded),
    .out_entries_held   (out_entries_held),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  sliding_window_event_limiter_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_event_time      (in_event_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_flood_detected (out_flood_detected),
    .out_recorded       (out_recorded),
    .out_entries_held   (out_entries_held),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sliding_window_event_limiter_top: done, errors");
      $finish;
    end
  end

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  task automatic send_event(input logic [STAMP_W-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_event_time <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic reg_access(input reg_sel_t sel, input logic wr, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [STAMP_W-1:0] window, input logic [RING_W-1:0] ring);
    int unsigned slots;
    drain();
    cur_window = window;
    slots      = ring;
    if (slots < 2) slots = 2;
    if (slots > MAX_SLOTS_DEF) slots = MAX_SLOTS_DEF;
    cur_cap = slots - 1;
    reg_access(REG_WINDOW, 1'b1, window);
    reg_access(REG_RING, 1'b1, {27'($urandom), ring});
    reg_access(REG_WINDOW, 1'b0, '0);
    reg_access(REG_RING, 1'b0, '0);
  endtask

  task automatic run_phase(input int n_items);
    longint unsigned    reach;
    logic [STAMP_W-1:0] step;
    logic [STAMP_W-1:0] t;
    int unsigned        pick;
    reach = (longint'(cur_window) * 2) / cur_cap + 1;
    if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
    now_tick = $urandom;
    for (int k = 0; k < n_items; k++) begin
      step = $urandom_range(0, 32'(reach));
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        now_tick += step;
        t = now_tick;
      end else if (pick < 90) begin
        t = now_tick - step;
      end else if (pick < 95) begin
        t = now_tick + 32'h8000_0000 + step;
      end else begin
        t = $urandom;
      end
      send_event(t);
      if (k % 40 == 39) drain();
    end
  endtask

  initial begin
    set_idle(38, 69);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(32'd100, 5'd4);
    foreach (EDGE_STAMPS[i]) send_event(EDGE_STAMPS[i]);
    configure(32'd0, 5'd1);
    foreach (ZERO_WINDOW_STAMPS[i]) send_event(ZERO_WINDOW_STAMPS[i]);
    configure(32'hFFFF_FFFF, 5'd2);
    foreach (FULL_WINDOW_STAMPS[i]) send_event(FULL_WINDOW_STAMPS[i]);

    for (int p = 0; p < 10; p++) begin
      if (p == 4) set_idle(69, 38);
      if (p == 8) set_idle(0, 0);
      case (p)
        0: configure($urandom_range(20, 200), 5'd16);
        1: configure(32'd0, 5'($urandom_range(2, 16)));
        2: configure(32'hFFFF_FFFF, 5'd3);
        3: configure($urandom_range(1, 5000), 5'd0);
        4: configure(32'h8000_0000, 5'd31);
        5: configure(32'h7FFF_FFFF, 5'd17);
        6: configure($urandom_range(1, 1 << 20), 5'd2);
        7: configure($urandom, 5'($urandom_range(0, 31)));
        8: configure($urandom_range(10, 1000), 5'($urandom_range(2, 16)));
        default: configure($urandom_range(1, 300), 5'd1);
      endcase
      run_phase(53);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_sliding_window_event_limiter_top: done, clean");
    end else begin
      $display("tb_sliding_window_event_limiter_top: done, errors");
    end
    $finish;
  end

endmodule
